/* sv/text_seed_resolver_defines.svh */
// Assertion macros for the verification file of the seed resolver.
`ifndef TEXT_SEED_RESOLVER_DEFINES_SVH
`define TEXT_SEED_RESOLVER_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define TSR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that a condition holds in the cycle after a trigger.
`define TSR_ASSERT_NEXT(label, trig, cond, msg) \
    `TSR_ASSERT_CLK(label, (trig) |=> (cond), msg)

`endif

/* sv/tsr_pkg.sv */
package tsr_pkg;

    typedef enum logic [1:0] {
        KIND_NUMERIC = 2'd0,
        KIND_HASHED  = 2'd1,
        KIND_RANDOM  = 2'd2
    } t_seed_kind;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] JAVA_MULT = 32'd31;
    localparam logic [31:0] JAVA_BASIS = 32'd0;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [1:0] COUNT_MAX = 2'd2;

endpackage

/* sv/text_seed_resolver.sv */
// Resolves a seed text, one byte per input transfer, into a 32-bit seed and a kind.
// A new byte is accepted every cycle; the byte is folded into the running hash
// (one constant multiply) and the 64-bit decimal accumulator (a times-ten add)
// in the same cycle, so the rate is one item per clock. The transfer marked
// last loads the result register, which drives the seed onto the output in the next
// cycle; the input stalls only when a last item arrives while an earlier
// result is still held by a stalled output. Writing hash_select discards any
// text in progress.
module text_seed_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_no_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_random_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_seed_value,
    output logic [1:0]  o_seed_kind
);

    logic        r_hash_select;
    logic [31:0] r_hash_running, n_hash_running;
    logic [31:0] r_hash_committed, n_hash_committed;
    logic [63:0] r_digit_value, n_digit_value;
    logic        r_content_started, n_content_started;
    logic [1:0]  r_content_count, n_content_count;
    logic        r_first_is_zero, n_first_is_zero;
    logic        r_sign_negative, n_sign_negative;
    logic        r_numeric_ok, n_numeric_ok;
    logic        r_digit_seen, n_digit_seen;
    logic        r_overflow, n_overflow;
    logic        r_space_pending, n_space_pending;

    logic        r_out_valid;
    logic [31:0] r_seed_value, n_seed_value;
    tsr_pkg::t_seed_kind r_seed_kind, n_seed_kind;

    logic        in_accept;
    logic        out_free;
    logic        c_space;
    logic        c_digit;
    logic        c_sign;
    logic [3:0]  digit;
    logic [67:0] times_ten;
    logic        take_overflow;
    logic [31:0] hashed;
    logic [31:0] basis;

    function automatic logic [31:0] hash_byte(input logic sel, input logic [31:0] h,
                                              input logic [7:0] c);
        logic [31:0] res;
        if (sel) begin
            res = h * tsr_pkg::JAVA_MULT + {24'd0, c};
        end else begin
            res = (h ^ {24'd0, c}) * tsr_pkg::FNV_PRIME;
        end
        return res;
    endfunction

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = i_last_byte && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign basis = r_hash_select ? tsr_pkg::JAVA_BASIS : tsr_pkg::FNV_BASIS;

    assign c_space = (i_text_byte == tsr_pkg::CHAR_SPACE)
                  || (i_text_byte >= tsr_pkg::CHAR_TAB && i_text_byte <= tsr_pkg::CHAR_CR);
    assign c_digit = (i_text_byte >= tsr_pkg::CHAR_ZERO) && (i_text_byte <= tsr_pkg::CHAR_NINE);
    assign c_sign  = (i_text_byte == tsr_pkg::CHAR_PLUS) || (i_text_byte == tsr_pkg::CHAR_MINUS);
    assign digit   = i_text_byte[3:0];

    assign times_ten = ({4'd0, r_digit_value} << 3) + ({4'd0, r_digit_value} << 1)
                     + {64'd0, digit};
    assign take_overflow = |times_ten[67:64];
    assign hashed = hash_byte(r_hash_select, r_hash_running, i_text_byte);

    always_comb begin
        n_hash_running    = r_hash_running;
        n_hash_committed  = r_hash_committed;
        n_digit_value     = r_digit_value;
        n_content_started = r_content_started;
        n_content_count   = r_content_count;
        n_first_is_zero   = r_first_is_zero;
        n_sign_negative   = r_sign_negative;
        n_numeric_ok      = r_numeric_ok;
        n_digit_seen      = r_digit_seen;
        n_overflow        = r_overflow;
        n_space_pending   = r_space_pending;
        if (!i_no_byte) begin
            if (c_space) begin
                if (r_content_started) begin
                    n_hash_running  = hashed;
                    n_space_pending = 1'b1;
                end
            end else begin
                if (!r_content_started) begin
                    n_content_started = 1'b1;
                    n_first_is_zero   = (i_text_byte == tsr_pkg::CHAR_ZERO);
                    if (c_sign) begin
                        n_sign_negative = (i_text_byte == tsr_pkg::CHAR_MINUS);
                    end else if (!c_digit) begin
                        n_numeric_ok = 1'b0;
                    end
                end else begin
                    if (r_space_pending || !c_digit) begin
                        n_numeric_ok = 1'b0;
                    end
                end
                if (c_digit) begin
                    n_digit_seen = 1'b1;
                    if (!r_overflow) begin
                        if (take_overflow) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_digit_value = times_ten[63:0];
                        end
                    end
                end
                n_hash_running   = hashed;
                n_hash_committed = hashed;
                n_space_pending  = 1'b0;
                if (r_content_count < tsr_pkg::COUNT_MAX) begin
                    n_content_count = r_content_count + 2'd1;
                end
            end
        end
    end

    always_comb begin
        if (n_content_count == 2'd0 || (n_content_count == 2'd1 && n_first_is_zero)) begin
            n_seed_value = i_random_word;
            n_seed_kind  = tsr_pkg::KIND_RANDOM;
        end else if (n_numeric_ok && n_digit_seen && !n_overflow) begin
            n_seed_value = n_sign_negative ? (32'd0 - n_digit_value[31:0])
                                           : n_digit_value[31:0];
            n_seed_kind  = tsr_pkg::KIND_NUMERIC;
        end else begin
            n_seed_value = n_hash_committed;
            n_seed_kind  = tsr_pkg::KIND_HASHED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_select     <= 1'b0;
            r_hash_running    <= tsr_pkg::FNV_BASIS;
            r_hash_committed  <= tsr_pkg::FNV_BASIS;
            r_digit_value     <= 64'd0;
            r_content_started <= 1'b0;
            r_content_count   <= 2'd0;
            r_first_is_zero   <= 1'b0;
            r_sign_negative   <= 1'b0;
            r_numeric_ok      <= 1'b1;
            r_digit_seen      <= 1'b0;
            r_overflow        <= 1'b0;
            r_space_pending   <= 1'b0;
        end else if (i_cfg_we) begin
            r_hash_select     <= i_cfg_data;
            r_hash_running    <= i_cfg_data ? tsr_pkg::JAVA_BASIS : tsr_pkg::FNV_BASIS;
            r_hash_committed  <= i_cfg_data ? tsr_pkg::JAVA_BASIS : tsr_pkg::FNV_BASIS;
            r_digit_value     <= 64'd0;
            r_content_started <= 1'b0;
            r_content_count   <= 2'd0;
            r_first_is_zero   <= 1'b0;
            r_sign_negative   <= 1'b0;
            r_numeric_ok      <= 1'b1;
            r_digit_seen      <= 1'b0;
            r_overflow        <= 1'b0;
            r_space_pending   <= 1'b0;
        end else if (in_accept) begin
            if (i_last_byte) begin
                r_hash_running    <= basis;
                r_hash_committed  <= basis;
                r_digit_value     <= 64'd0;
                r_content_started <= 1'b0;
                r_content_count   <= 2'd0;
                r_first_is_zero   <= 1'b0;
                r_sign_negative   <= 1'b0;
                r_numeric_ok      <= 1'b1;
                r_digit_seen      <= 1'b0;
                r_overflow        <= 1'b0;
                r_space_pending   <= 1'b0;
            end else begin
                r_hash_running    <= n_hash_running;
                r_hash_committed  <= n_hash_committed;
                r_digit_value     <= n_digit_value;
                r_content_started <= n_content_started;
                r_content_count   <= n_content_count;
                r_first_is_zero   <= n_first_is_zero;
                r_sign_negative   <= n_sign_negative;
                r_numeric_ok      <= n_numeric_ok;
                r_digit_seen      <= n_digit_seen;
                r_overflow        <= n_overflow;
                r_space_pending   <= n_space_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_accept && i_last_byte && !i_cfg_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_accept && i_last_byte) begin
            r_seed_value <= n_seed_value;
            r_seed_kind  <= n_seed_kind;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_seed_value = r_seed_value;
    assign o_seed_kind  = r_seed_kind;

endmodule

/* sv/tsr_checker.sv */
`include "text_seed_resolver_defines.svh"

module tsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_seed_value
);

    logic in_xfer;

    assign in_xfer = i_in_valid && !o_in_stall && !i_cfg_we;

    `TSR_ASSERT_NEXT(a_last_gives_result, in_xfer && i_last_byte, o_out_valid, "last transfer gave no result")
    `TSR_ASSERT_NEXT(a_no_spurious_result, !o_out_valid && !(in_xfer && i_last_byte), !o_out_valid, "result without a last transfer")
    `TSR_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall, o_out_valid, "stalled result dropped")
    `TSR_ASSERT_NEXT(a_value_held, o_out_valid && i_out_stall, $stable(o_seed_value), "stalled seed changed")

endmodule

bind text_seed_resolver tsr_checker u_tsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_byte  (i_last_byte),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_seed_value (o_seed_value)
);
